// ----- hdl/rdc_pkg.sv -----
// ----------------------------------------------------------------------------
// Grid ray caster package
// Shared types and fixed widths for the grid DDA ray caster.
// ----------------------------------------------------------------------------
package rdc_pkg;

    // Ray component width: covers the widest camera-x product.
    localparam int RW      = 28;
    localparam int CXW     = 25;
    localparam int DISTW   = 26;
    localparam int PW      = 54;
    localparam int DIV_NW  = 54;
    localparam int DIV_DW  = 42;
    localparam int PERPW   = 42;
    localparam int LHW     = 28;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;

    localparam logic [LHW-1:0] LH_HUGE  = LHW'(1) << 27;
    localparam logic [23:0]    PERP_SAT = 24'hFFFFFF;

    localparam logic [2:0] REG_CAM_X  = 3'd0;
    localparam logic [2:0] REG_CAM_Y  = 3'd1;
    localparam logic [2:0] REG_DIR_X  = 3'd2;
    localparam logic [2:0] REG_DIR_Y  = 3'd3;
    localparam logic [2:0] REG_PLN_X  = 3'd4;
    localparam logic [2:0] REG_PLN_Y  = 3'd5;
    localparam logic [2:0] REG_TEX_W  = 3'd6;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CAST  = 1'b1;

    typedef struct packed {
        logic       req_type;
        logic [9:0] column;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [7:0] cell_value;
    } req_t;

    typedef struct packed {
        logic [9:0]  ray_column;
        logic        hit_found;
        logic        hit_side;
        logic [5:0]  hit_x;
        logic [5:0]  hit_y;
        logic [7:0]  hit_code;
        logic [23:0] perp_dist;
        logic [8:0]  span_start;
        logic [8:0]  span_end;
        logic [7:0]  texel_x;
    } res_t;

    typedef struct packed {
        logic [21:0]        cam_pos_x;
        logic [21:0]        cam_pos_y;
        logic signed [17:0] view_dir_x;
        logic signed [17:0] view_dir_y;
        logic signed [17:0] plane_x;
        logic signed [17:0] plane_y;
        logic [8:0]         tex_width;
    } cfg_t;

    typedef struct packed {
        logic       is_cast;
        logic [9:0] column;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic [7:0] cell_value;
    } entry_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DIV_NW-1:0] quot;
    } div_rsp_t;

endpackage

// ----- hdl/rdc_div.sv -----
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, one quotient bit per clock.
// ----------------------------------------------------------------------------
module rdc_div (
    input  logic            clk,
    input  logic            rst_n,
    input  rdc_pkg::div_req_t req,
    output rdc_pkg::div_rsp_t rsp
);
    import rdc_pkg::*;

    localparam int CNTW = $clog2(DIV_NW + 1);

    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic [DIV_DW:0]   trial;
    logic              fits;

    assign trial = {rem_reg, quo_reg[DIV_NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNTW'(1);
                if (cnt_reg == CNTW'(DIV_NW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.num;
            den_reg <= req.den;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= DIV_DW'(trial - {1'b0, den_reg});
            end
            else
            begin
                rem_reg <= trial[DIV_DW-1:0];
            end
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule

// ----- hdl/rdc_front.sv -----
// ----------------------------------------------------------------------------
// Request front end
// Accepts requests, drops map writes outside the grid, and queues the rest.
// ----------------------------------------------------------------------------
module rdc_front #(
    parameter int MAP_SIZE = 64
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  rdc_pkg::req_t   req,
    output logic            busy,
    input  logic            clr_busy,
    input  logic            pop,
    output logic            q_valid,
    output rdc_pkg::entry_t q_data
);
    import rdc_pkg::*;

    entry_t           q_mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     cnt_reg;
    logic             accept;
    logic             in_map;
    logic             push;
    logic             do_pop;
    entry_t           ent;

    assign busy    = (cnt_reg == (QAW+1)'(QDEPTH)) || clr_busy;
    assign accept  = start && !busy;
    assign in_map  = (32'(req.cell_x) < MAP_SIZE) && (32'(req.cell_y) < MAP_SIZE);
    assign push    = accept && ((req.req_type == REQ_CAST) || in_map);
    assign q_valid = cnt_reg != '0;
    assign do_pop  = pop && q_valid;
    assign q_data  = q_mem[rd_ptr_reg];

    always_comb
    begin
        ent.is_cast    = req.req_type == REQ_CAST;
        ent.column     = req.column;
        ent.cell_x     = req.cell_x;
        ent.cell_y     = req.cell_y;
        ent.cell_value = req.cell_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            if (push && !do_pop)
            begin
                cnt_reg <= cnt_reg + (QAW+1)'(1);
            end
            else if (do_pop && !push)
            begin
                cnt_reg <= cnt_reg - (QAW+1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= ent;
        end
    end

endmodule

// ----- hdl/rdc_back.sv -----
// ----------------------------------------------------------------------------
// Ray walker back end
// Holds the map, walks each ray across the grid, and forms the wall result.
// ----------------------------------------------------------------------------
module rdc_back #(
    parameter int MAP_SIZE  = 64,
    parameter int SCREEN_W  = 640,
    parameter int SCREEN_H  = 480,
    parameter int MAX_STEPS = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rdc_pkg::cfg_t   cfg,
    input  logic            q_valid,
    input  rdc_pkg::entry_t q_data,
    output logic            pop,
    output logic            clr_busy,
    output logic            result_valid,
    output rdc_pkg::res_t   result
);
    import rdc_pkg::*;

    localparam int DEPTH = MAP_SIZE * MAP_SIZE;
    localparam int AW    = $clog2(DEPTH);
    localparam int CB    = $clog2(MAP_SIZE);
    localparam int CW    = CB + 2;
    localparam int SW    = $clog2(MAX_STEPS + 1);
    localparam logic signed [CW-1:0] MAP_LIM = CW'(MAP_SIZE);
    // Rounded-up reciprocal of the screen width, scaled by 2^37. Multiplying the
    // column by it and dropping 20 bits gives floor(column * 2^17 / SCREEN_W)
    // exactly for every 10-bit column.
    localparam logic [33:0] CX_MUL = 34'(((64'd1 << 37) + 64'(SCREEN_W) - 64'd1)
                                         / 64'(SCREEN_W));

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CAMX  = 5'd1;
    localparam logic [4:0] S_CAMW  = 5'd2;
    localparam logic [4:0] S_RAYX  = 5'd3;
    localparam logic [4:0] S_RAYY  = 5'd4;
    localparam logic [4:0] S_RAYW  = 5'd5;
    localparam logic [4:0] S_SETUP = 5'd6;
    localparam logic [4:0] S_PX    = 5'd7;
    localparam logic [4:0] S_PY    = 5'd8;
    localparam logic [4:0] S_PYW   = 5'd9;
    localparam logic [4:0] S_STEP  = 5'd10;
    localparam logic [4:0] S_READ  = 5'd11;
    localparam logic [4:0] S_LOOK  = 5'd12;
    localparam logic [4:0] S_SIDE  = 5'd13;
    localparam logic [4:0] S_PERP  = 5'd14;
    localparam logic [4:0] S_PERPW = 5'd15;
    localparam logic [4:0] S_LH    = 5'd16;
    localparam logic [4:0] S_LHW   = 5'd17;
    localparam logic [4:0] S_TM1   = 5'd18;
    localparam logic [4:0] S_TM2   = 5'd19;
    localparam logic [4:0] S_TM3   = 5'd20;
    localparam logic [4:0] S_TDIV  = 5'd21;
    localparam logic [4:0] S_TDIVW = 5'd22;
    localparam logic [4:0] S_FIN   = 5'd23;
    localparam logic [4:0] S_NOHIT = 5'd24;

    logic [4:0]  state_reg, state_next;
    logic        clr_reg;
    logic [AW-1:0] clr_cnt_reg;

    logic [7:0]  map_mem [DEPTH];
    logic [7:0]  rd_data_reg;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic        wr_en;
    logic        rd_en;

    div_req_t    div_req;
    div_rsp_t    div_rsp;

    logic [9:0]            col_reg;
    logic [43:0]           cxp_reg;
    logic signed [CXW-1:0] cx_reg;
    logic signed [42:0]    smul_reg;
    logic signed [17:0]    pl_sel;
    logic signed [RW-1:0]  rx_reg, ry_reg;
    logic signed [RW-1:0]  ray_new;
    logic signed [26:0]    smul_sh;
    logic [RW-1:0]         ax_reg, ay_reg;
    logic                  negx_reg, negy_reg;
    logic signed [CW-1:0]  mx_reg, my_reg;
    logic [DISTW-1:0]      dx_reg, dy_reg, num_reg;
    logic [PW-1:0]         px_reg, py_reg;
    logic [SW-1:0]         step_reg;
    logic                  side_reg;
    logic [7:0]            code_reg;
    logic [RW-1:0]         den_reg, along_reg;
    logic                  neg_reg;
    logic [15:0]           base16_reg;
    logic [PERPW-1:0]      perp_reg;
    logic [LHW-1:0]        lh_reg;
    logic [15:0]           t16_reg;
    logic [39:0]           tlo_reg;
    logic [PW-1:0]         tnum_reg;
    logic [RW-1:0]         mul_a;
    logic [16:0]           mul_b;
    logic [44:0]           prod_reg;
    logic                  in_bounds;
    logic                  cam_out;
    logic [16:0]           fx_new, fy_new;
    logic                  x_step;
    res_t                  res_reg;
    logic                  done_reg;

    // Finish-stage arithmetic
    logic [15:0]        frac;
    logic [24:0]        tprod;
    logic [8:0]         texel9, texel_m;
    logic               mirror;
    logic [LHW:0]       lh1;
    logic signed [29:0] st_s, en_s;
    logic [CW+5:0]      mx_e, my_e;

    rdc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign clr_busy     = clr_reg;
    assign pop          = (state_reg == S_IDLE) && q_valid && !clr_reg;
    assign result_valid = done_reg;
    assign result       = res_reg;

    // ---------------- map memory ----------------
    assign rd_addr   = AW'(my_reg[CB-1:0]) * AW'(MAP_SIZE) + AW'(mx_reg[CB-1:0]);
    assign wr_addr   = AW'(q_data.cell_y) * AW'(MAP_SIZE) + AW'(q_data.cell_x);
    assign wr_en     = pop && !q_data.is_cast;
    assign in_bounds = !mx_reg[CW-1] && !my_reg[CW-1] && (mx_reg < MAP_LIM)
                       && (my_reg < MAP_LIM);
    assign rd_en     = (state_reg == S_READ) && in_bounds;

    always_ff @(posedge clk)
    begin
        if (clr_reg)
        begin
            map_mem[clr_cnt_reg] <= 8'd0;
        end
        else if (wr_en)
        begin
            map_mem[wr_addr] <= q_data.cell_value;
        end
        if (rd_en)
        begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

    // ---------------- shared arithmetic ----------------
    assign pl_sel  = (state_reg == S_RAYX) ? cfg.plane_x : cfg.plane_y;
    assign smul_sh = smul_reg[42:16];
    assign ray_new = (state_reg == S_RAYY)
                     ? ({{(RW-18){cfg.view_dir_x[17]}}, cfg.view_dir_x} + {smul_sh[26], smul_sh})
                     : ({{(RW-18){cfg.view_dir_y[17]}}, cfg.view_dir_y} + {smul_sh[26], smul_sh});

    always_comb
    begin
        mul_a = ay_reg;
        mul_b = dx_reg[16:0];
        case (state_reg)
            S_PY:
            begin
                mul_a = ax_reg;
                mul_b = dy_reg[16:0];
            end
            S_TM1:
            begin
                mul_a = RW'(num_reg);
                mul_b = {3'b0, along_reg[13:0]};
            end
            S_TM2:
            begin
                mul_a = RW'(num_reg);
                mul_b = {3'b0, along_reg[27:14]};
            end
            default:
            begin
                mul_a = ay_reg;
                mul_b = dx_reg[16:0];
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        smul_reg <= pl_sel * cx_reg;
    end

    always_comb
    begin
        div_req.start = 1'b0;
        div_req.num   = '0;
        div_req.den   = '0;
        case (state_reg)
            S_PERP:
            begin
                div_req.start = 1'b1;
                div_req.num   = DIV_NW'({num_reg, 16'b0});
                div_req.den   = DIV_DW'(den_reg);
            end
            S_LH:
            begin
                div_req.start = perp_reg != '0;
                div_req.num   = DIV_NW'(SCREEN_H) << 16;
                div_req.den   = DIV_DW'(perp_reg);
            end
            S_TDIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = tnum_reg;
                div_req.den   = DIV_DW'(den_reg);
            end
            default:
            begin
                div_req.start = 1'b0;
            end
        endcase
    end

    assign cam_out = (32'(cfg.cam_pos_x[21:16]) >= MAP_SIZE)
                     || (32'(cfg.cam_pos_y[21:16]) >= MAP_SIZE);
    assign fx_new  = rx_reg[RW-1] ? {1'b0, cfg.cam_pos_x[15:0]}
                                  : 17'h10000 - {1'b0, cfg.cam_pos_x[15:0]};
    assign fy_new  = ry_reg[RW-1] ? {1'b0, cfg.cam_pos_y[15:0]}
                                  : 17'h10000 - {1'b0, cfg.cam_pos_y[15:0]};
    assign x_step  = px_reg < py_reg;

    // ---------------- control ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop && q_data.is_cast)
                begin
                    state_next = S_CAMX;
                end
            end
            S_CAMX:  state_next = S_CAMW;
            S_CAMW:  state_next = S_RAYX;
            S_RAYX:  state_next = S_RAYY;
            S_RAYY:  state_next = S_RAYW;
            S_RAYW:  state_next = S_SETUP;
            S_SETUP: state_next = cam_out ? S_NOHIT : S_PX;
            S_PX:    state_next = S_PY;
            S_PY:    state_next = S_PYW;
            S_PYW:   state_next = S_STEP;
            S_STEP:  state_next = (step_reg == SW'(MAX_STEPS)) ? S_NOHIT : S_READ;
            S_READ:  state_next = in_bounds ? S_LOOK : S_NOHIT;
            S_LOOK:  state_next = (rd_data_reg != 8'd0) ? S_SIDE : S_STEP;
            S_SIDE:
            begin
                if (side_reg ? (ay_reg == '0) : (ax_reg == '0))
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_PERP;
                end
            end
            S_PERP:  state_next = S_PERPW;
            S_PERPW:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_LH;
                end
            end
            S_LH:    state_next = (perp_reg == '0) ? S_TM1 : S_LHW;
            S_LHW:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_TM1;
                end
            end
            S_TM1:   state_next = S_TM2;
            S_TM2:   state_next = S_TM3;
            S_TM3:   state_next = S_TDIV;
            S_TDIV:  state_next = S_TDIVW;
            S_TDIVW:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:   state_next = S_IDLE;
            S_NOHIT: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            done_reg    <= 1'b0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == S_FIN) || (state_reg == S_NOHIT);
            if (clr_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    clr_reg <= 1'b0;
                end
            end
        end
    end

    // ---------------- finish arithmetic ----------------
    always_comb
    begin
        frac    = neg_reg ? (base16_reg - t16_reg) : (base16_reg + t16_reg);
        tprod   = frac * cfg.tex_width;
        texel9  = tprod[24:16];
        mirror  = (!side_reg && !rx_reg[RW-1] && (rx_reg != '0))
                  || (side_reg && ry_reg[RW-1]);
        texel_m = mirror ? (cfg.tex_width - 9'd1 - texel9) : texel9;
        lh1     = {1'b0, lh_reg} + (LHW+1)'(1);
        st_s    = 30'(SCREEN_H / 2) - {2'b0, lh1[LHW:1]};
        en_s    = {3'b0, lh_reg[LHW-1:1]} + 30'(SCREEN_H / 2);
        if (st_s < 0)
        begin
            st_s = '0;
        end
        if (en_s > 30'(SCREEN_H))
        begin
            en_s = 30'(SCREEN_H);
        end
        mx_e = {6'b0, mx_reg};
        my_e = {6'b0, my_reg};
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                col_reg <= q_data.column;
            end
            S_CAMX:
            begin
                cxp_reg <= col_reg * CX_MUL;
            end
            S_CAMW:
            begin
                cx_reg <= signed'(CXW'(cxp_reg[43:20]) - CXW'(65536));
            end
            S_RAYY:
            begin
                rx_reg <= ray_new;
            end
            S_RAYW:
            begin
                ry_reg <= ray_new;
            end
            S_SETUP:
            begin
                ax_reg   <= rx_reg[RW-1] ? RW'(-rx_reg) : RW'(rx_reg);
                ay_reg   <= ry_reg[RW-1] ? RW'(-ry_reg) : RW'(ry_reg);
                negx_reg <= rx_reg[RW-1];
                negy_reg <= ry_reg[RW-1];
                mx_reg   <= CW'(cfg.cam_pos_x[21:16]);
                my_reg   <= CW'(cfg.cam_pos_y[21:16]);
                dx_reg   <= DISTW'(fx_new);
                dy_reg   <= DISTW'(fy_new);
            end
            S_PY:
            begin
                px_reg <= PW'(prod_reg);
            end
            S_PYW:
            begin
                py_reg   <= PW'(prod_reg);
                step_reg <= '0;
            end
            S_STEP:
            begin
                step_reg <= step_reg + SW'(1);
                if (x_step)
                begin
                    num_reg  <= dx_reg;
                    dx_reg   <= dx_reg + DISTW'(65536);
                    px_reg   <= px_reg + PW'({ay_reg, 16'b0});
                    mx_reg   <= negx_reg ? mx_reg - CW'(1) : mx_reg + CW'(1);
                    side_reg <= 1'b0;
                end
                else
                begin
                    num_reg  <= dy_reg;
                    dy_reg   <= dy_reg + DISTW'(65536);
                    py_reg   <= py_reg + PW'({ax_reg, 16'b0});
                    my_reg   <= negy_reg ? my_reg - CW'(1) : my_reg + CW'(1);
                    side_reg <= 1'b1;
                end
            end
            S_LOOK:
            begin
                code_reg <= rd_data_reg;
            end
            S_SIDE:
            begin
                den_reg    <= side_reg ? ay_reg : ax_reg;
                along_reg  <= side_reg ? ax_reg : ay_reg;
                neg_reg    <= side_reg ? negx_reg : negy_reg;
                base16_reg <= side_reg ? cfg.cam_pos_x[15:0] : cfg.cam_pos_y[15:0];
                // A zero ray component on the crossed side gives a saturated distance.
                perp_reg   <= PERPW'(PERP_SAT);
                lh_reg     <= '0;
                t16_reg    <= '0;
            end
            S_PERPW:
            begin
                perp_reg <= div_rsp.quot[PERPW-1:0];
            end
            S_LH:
            begin
                lh_reg <= LH_HUGE;
            end
            S_LHW:
            begin
                lh_reg <= div_rsp.quot[LHW-1:0];
            end
            S_TM2:
            begin
                tlo_reg <= prod_reg[39:0];
            end
            S_TM3:
            begin
                tnum_reg <= PW'(tlo_reg) + (PW'(prod_reg) << 14);
            end
            S_TDIVW:
            begin
                t16_reg <= div_rsp.quot[15:0];
            end
            S_FIN:
            begin
                res_reg.ray_column <= col_reg;
                res_reg.hit_found  <= 1'b1;
                res_reg.hit_side   <= side_reg;
                res_reg.hit_x      <= mx_e[5:0];
                res_reg.hit_y      <= my_e[5:0];
                res_reg.hit_code   <= code_reg;
                res_reg.perp_dist  <= (perp_reg > PERPW'(PERP_SAT)) ? PERP_SAT
                                                                   : perp_reg[23:0];
                res_reg.span_start <= st_s[8:0];
                res_reg.span_end   <= en_s[8:0];
                res_reg.texel_x    <= texel_m[7:0];
            end
            S_NOHIT:
            begin
                // The column is the leading field; every other field is zero.
                res_reg <= res_t'({col_reg, {($bits(res_t) - 10){1'b0}}});
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- hdl/grid_ray_dda_caster.sv -----
// ----------------------------------------------------------------------------
// Grid DDA ray caster
// Casts one ray per screen column through a loadable wall map.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Map writes produce no
// result and are applied by the walker while it is idle; a cast produces one
// result, shown for a single cycle with result_valid, and the receiver must
// take it then. A cast that reaches a wall passes through ray setup (camera x
// by a constant reciprocal multiply, ray components, first side products), a
// step of compare, map read and wall test for each grid cell entered, and up
// to three waits on the one bit-per-cycle divider (distance, line height, wall
// offset). A cast that misses ends when its ray leaves the map or after
// MAX_STEPS steps, or at once when the camera is outside the map. A four-entry
// queue holds waiting requests; busy is high while it is full and during the
// map clearing pass after reset that zeroes all MAP_SIZE*MAP_SIZE cells.
// Configuration registers may be written at any cycle the block is idle.
module grid_ray_dda_caster #(
    parameter int MAP_SIZE  = 64,
    parameter int SCREEN_W  = 640,
    parameter int SCREEN_H  = 480,
    parameter int MAX_STEPS = 128
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rdc_pkg::req_t req,
    output logic          result_valid,
    output rdc_pkg::res_t result,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_idx,
    input  logic [21:0]   cfg_wdata
);
    import rdc_pkg::*;

    cfg_t   cfg_reg;
    logic   pop;
    logic   clr_busy;
    logic   q_valid;
    entry_t q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cam_pos_x  <= '0;
            cfg_reg.cam_pos_y  <= '0;
            cfg_reg.view_dir_x <= 18'sd65536;
            cfg_reg.view_dir_y <= '0;
            cfg_reg.plane_x    <= '0;
            cfg_reg.plane_y    <= 18'sd43253;
            cfg_reg.tex_width  <= 9'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_CAM_X: cfg_reg.cam_pos_x  <= cfg_wdata;
                REG_CAM_Y: cfg_reg.cam_pos_y  <= cfg_wdata;
                REG_DIR_X: cfg_reg.view_dir_x <= cfg_wdata[17:0];
                REG_DIR_Y: cfg_reg.view_dir_y <= cfg_wdata[17:0];
                REG_PLN_X: cfg_reg.plane_x    <= cfg_wdata[17:0];
                REG_PLN_Y: cfg_reg.plane_y    <= cfg_wdata[17:0];
                REG_TEX_W: cfg_reg.tex_width  <= cfg_wdata[8:0];
                default:
                begin
                end
            endcase
        end
    end

    rdc_front #(
        .MAP_SIZE (MAP_SIZE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req      (req),
        .busy     (busy),
        .clr_busy (clr_busy),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_data   (q_data)
    );

    rdc_back #(
        .MAP_SIZE  (MAP_SIZE),
        .SCREEN_W  (SCREEN_W),
        .SCREEN_H  (SCREEN_H),
        .MAX_STEPS (MAX_STEPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .clr_busy     (clr_busy),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid ray caster testbench
// Loads wall maps, sweeps camera settings and casts columns through the block.
// Every transaction is mirrored in a behavioral ray walker, and each result is
// compared field by field with the oldest predicted ray.
// ----------------------------------------------------------------------------
module testbench;
    import rdc_pkg::*;

    localparam int  MAP_N      = 64;
    localparam int  SCR_W      = 640;
    localparam int  SCR_H      = 480;
    localparam int  STEP_LIMIT = 128;
    localparam int  SETTLE     = 800;
    localparam int  STALL_MAX  = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    req_t        req;
    logic        result_valid;
    res_t        result;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [21:0] cfg_wdata;

    // Mirror of the block state.
    logic [7:0]         wall_map [MAP_N*MAP_N];
    logic [21:0]        cam_x, cam_y;
    logic signed [17:0] dir_x, dir_y, pln_x, pln_y;
    logic [8:0]         tex_w;

    res_t expected_rays [$];
    int   error_count = 0;
    int   cast_count  = 0;
    int   hit_count   = 0;
    int   write_count = 0;
    int   idle_pct    = 0;
    int   quiet_cycles = 0;
    bit   activity;

    grid_ray_dda_caster #(
        .MAP_SIZE  (MAP_N),
        .SCREEN_W  (SCR_W),
        .SCREEN_H  (SCR_H),
        .MAX_STEPS (STEP_LIMIT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic res_t predict_ray(logic [9:0] col);
        longint cx, rx, ry, ax, ay, mx, my, sx, sy, fx, fy, nx, ny, dx, dy;
        longint num, den, along, base, perp, lh, t, span_lo, span_hi, hitc, texel;
        int     side;
        bit     hit, neg;
        logic [7:0] code;
        res_t   r;
        r = '0;
        r.ray_column = col;
        side = 0;
        hit = 0;
        code = 8'd0;
        nx = 0;
        ny = 0;
        cx = (2 * longint'(col) * 65536) / SCR_W - 65536;
        rx = longint'(dir_x) + ((longint'(pln_x) * cx) >>> 16);
        ry = longint'(dir_y) + ((longint'(pln_y) * cx) >>> 16);
        ax = rx < 0 ? -rx : rx;
        ay = ry < 0 ? -ry : ry;
        mx = longint'(cam_x) >> 16;
        my = longint'(cam_y) >> 16;
        if (mx >= MAP_N || my >= MAP_N)
            return r;
        sx = rx < 0 ? -1 : 1;
        sy = ry < 0 ? -1 : 1;
        fx = rx < 0 ? longint'(cam_x[15:0]) : 65536 - longint'(cam_x[15:0]);
        fy = ry < 0 ? longint'(cam_y[15:0]) : 65536 - longint'(cam_y[15:0]);
        for (int k = 0; k < STEP_LIMIT; k++)
        begin
            dx = fx + nx * 65536;
            dy = fy + ny * 65536;
            // Ties step along y.
            if (dx * ay < dy * ax)
            begin
                nx++;
                mx += sx;
                side = 0;
            end
            else
            begin
                ny++;
                my += sy;
                side = 1;
            end
            if (mx < 0 || my < 0 || mx >= MAP_N || my >= MAP_N)
                break;
            code = wall_map[my * MAP_N + mx];
            if (code != 0)
            begin
                hit = 1;
                break;
            end
        end
        if (!hit)
            return r;
        if (side == 0)
        begin
            num = fx + (nx - 1) * 65536;
            den = ax;
            along = ay;
            base = longint'(cam_y);
            neg = ry < 0;
        end
        else
        begin
            num = fy + (ny - 1) * 65536;
            den = ay;
            along = ax;
            base = longint'(cam_x);
            neg = rx < 0;
        end
        if (den == 0)
        begin
            perp = 64'hFFFFFF;
            lh = 0;
            t = 0;
        end
        else
        begin
            perp = (num << 16) / den;
            lh = perp != 0 ? (longint'(SCR_H) << 16) / perp : (64'd1 << 27);
            if (lh > (64'd1 << 27))
                lh = 64'd1 << 27;
            t = num * along / den;
            if (perp > 64'hFFFFFF)
                perp = 64'hFFFFFF;
        end
        span_lo = SCR_H / 2 - (lh + 1) / 2;
        if (span_lo < 0)
            span_lo = 0;
        span_hi = lh / 2 + SCR_H / 2;
        if (span_hi > SCR_H)
            span_hi = SCR_H;
        hitc = neg ? base - t : base + t;
        texel = ((hitc & 64'hFFFF) * longint'(tex_w)) >> 16;
        if ((side == 0 && rx > 0) || (side == 1 && ry < 0))
            texel = longint'(tex_w) - 1 - texel;
        r.hit_found  = 1'b1;
        r.hit_side   = side[0];
        r.hit_x      = mx[5:0];
        r.hit_y      = my[5:0];
        r.hit_code   = code;
        r.perp_dist  = perp[23:0];
        r.span_start = span_lo[8:0];
        r.span_end   = span_hi[8:0];
        r.texel_x    = texel[7:0];
        return r;
    endfunction

    // Sends one transaction and records its effect once it is taken.
    task automatic send_item(req_t item);
        bit taken;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        start <= 1'b1;
        req   <= item;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        while (!taken);
        activity = 1'b1;
        if (item.req_type == REQ_WRITE)
        begin
            wall_map[item.cell_y * MAP_N + item.cell_x] = item.cell_value;
            write_count++;
        end
        else
        begin
            expected_rays.push_back(predict_ray(item.column));
            cast_count++;
        end
    endtask

    task automatic write_cell(int x, int y, int v);
        req_t item;
        item = '0;
        item.req_type   = REQ_WRITE;
        item.column     = 10'($urandom_range(1023));
        item.cell_x     = 6'(x);
        item.cell_y     = 6'(y);
        item.cell_value = 8'(v);
        send_item(item);
    endtask

    task automatic cast_column(int col);
        req_t item;
        item = '0;
        item.req_type   = REQ_CAST;
        item.column     = 10'(col);
        item.cell_x     = 6'($urandom_range(63));
        item.cell_y     = 6'($urandom_range(63));
        item.cell_value = 8'($urandom_range(255));
        send_item(item);
    endtask

    // Lets every queued transaction finish, including trailing map writes.
    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (expected_rays.size() != 0 || busy)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_camera(int px, int py, int vx, int vy, int qx, int qy, int tw);
        int vals [7];
        logic [2:0] regs [7];
        vals = '{px, py, vx, vy, qx, qy, tw};
        regs = '{REG_CAM_X, REG_CAM_Y, REG_DIR_X, REG_DIR_Y, REG_PLN_X, REG_PLN_Y,
                 REG_TEX_W};
        drain();
        for (int i = 0; i < 7; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_idx   <= regs[i];
            cfg_wdata <= 22'(vals[i]);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cam_x = 22'(px);
        cam_y = 22'(py);
        dir_x = 18'(vx);
        dir_y = 18'(vy);
        pln_x = 18'(qx);
        pln_y = 18'(qy);
        tex_w = 9'(tw);
    endtask

    task automatic random_camera;
        int tw;
        case ($urandom_range(9))
            0: tw = 0;
            1: tw = 511;
            2: tw = 256;
            3: tw = 1;
            default: tw = $urandom_range(256, 1);
        endcase
        // A zero fraction now and then puts the camera right on a boundary.
        program_camera(($urandom_range(62, 1) << 16) | ($urandom_range(1) ? 0 : $urandom_range(65535)),
                       ($urandom_range(62, 1) << 16) | ($urandom_range(1) ? 0 : $urandom_range(65535)),
                       $urandom_range(262143), $urandom_range(262143),
                       $urandom_range(262143), $urandom_range(262143), tw);
    endtask

    task automatic test_default_view;
        write_cell(3, 0, 255);
        write_cell(0, 1, 1);
        write_cell(63, 63, 128);
        write_cell(1, 0, 0);
        write_cell(2, 2, 7);
        cast_column(0);
        cast_column(320);
        cast_column(639);
        cast_column(640);
        cast_column(1023);
    endtask

    task automatic test_camera_extremes;
        program_camera(4194303, 4194303, -131072, -131072, 131071, 0, 511);
        write_cell(61, 61, 9);
        cast_column(0);
        cast_column(1023);
        // Camera on a cell corner next to a wall: zero distance.
        program_camera(5 << 16, 5 << 16, -65536, 0, 0, 131071, 0);
        write_cell(4, 5, 33);
        cast_column(320);
        cast_column(100);
        // Zero ray along both axes.
        program_camera(2 << 16, 2 << 16, 0, 0, 0, 0, 256);
        write_cell(2, 3, 44);
        cast_column(320);
        program_camera(5 << 16, 30 << 16, 131071, 0, 0, -131072, 1);
        write_cell(40, 30, 200);
        cast_column(320);
        cast_column(0);
    endtask

    task automatic test_random_scenes(int count, int pct);
        idle_pct = pct;
        for (int n = 0; n < count; n++)
        begin
            if (n % 150 == 0)
                random_camera();
            if (n % 150 == 75)
                drain();
            if ($urandom_range(99) < 40)
                write_cell($urandom_range(63), $urandom_range(63),
                           $urandom_range(3) == 0 ? 0 : $urandom_range(255, 1));
            else
                cast_column($urandom_range(3) == 0 ? $urandom_range(1023)
                                                   : $urandom_range(SCR_W - 1));
        end
    endtask

    task automatic check_field(string name, logic [23:0] want, logic [23:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(negedge clk)
    begin
        if (rst_n && result_valid)
        begin
            res_t want;
            activity = 1'b1;
            if (expected_rays.size() == 0)
            begin
                $display("%0t: unexpected ray result for column %0d", $time,
                         result.ray_column);
                error_count++;
            end
            else
            begin
                want = expected_rays.pop_front();
                if (want.hit_found)
                    hit_count++;
                check_field("ray_column", want.ray_column, result.ray_column);
                check_field("hit_found", want.hit_found, result.hit_found);
                check_field("hit_side", want.hit_side, result.hit_side);
                check_field("hit_x", want.hit_x, result.hit_x);
                check_field("hit_y", want.hit_y, result.hit_y);
                check_field("hit_code", want.hit_code, result.hit_code);
                check_field("perp_dist", want.perp_dist, result.perp_dist);
                check_field("span_start", want.span_start, result.span_start);
                check_field("span_end", want.span_end, result.span_end);
                check_field("texel_x", want.texel_x, result.texel_x);
            end
        end
    end

    always @(negedge clk)
    begin
        if (activity)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        activity = 1'b0;
        if (quiet_cycles >= STALL_MAX)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_MAX);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_idx   = REG_CAM_X;
        cfg_wdata = '0;
        activity  = 1'b0;
        for (int i = 0; i < MAP_N * MAP_N; i++)
            wall_map[i] = 8'd0;
        cam_x = '0;
        cam_y = '0;
        dir_x = 18'sd65536;
        dir_y = '0;
        pln_x = '0;
        pln_y = 18'sd43253;
        tex_w = 9'd64;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_view();
        test_camera_extremes();
        test_random_scenes(600, 30);
        test_random_scenes(600, 79);
        test_random_scenes(600, 0);
        drain();

        $display("Cast %0d rays (%0d hits) and wrote %0d map cells over many camera setups.",
                 cast_count, hit_count, write_count);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ----- grid_ray_dda_caster.f -----
hdl/rdc_pkg.sv
hdl/rdc_div.sv
hdl/rdc_front.sv
hdl/rdc_back.sv
hdl/grid_ray_dda_caster.sv
tb/sv/testbench.sv
